// ===== rtl/mhtr_pkg.sv =====
// ----------------------------------------------------------------------------
// mhtr_pkg
// Shared constants and types for the mp4 header timescale rewriter.
// ----------------------------------------------------------------------------
package mhtr_pkg;

  localparam int HOLD_BYTES        = 12;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int HOLD_IDX_W        = $clog2(HOLD_BYTES);
  localparam int LEN_W             = $clog2(HOLD_BYTES + 1);
  localparam int POS_W             = 6;
  localparam int STAT_W            = 16;

  localparam logic [31:0] TAG_MOVIE = 32'h6D76_6864;
  localparam logic [31:0] TAG_MEDIA = 32'h6D64_6864;

  localparam logic [1:0] SHIFT_RESET = 2'd1;

  localparam logic [POS_W-1:0] START_SHORT = 6'd12;
  localparam logic [POS_W-1:0] START_LONG  = 6'd20;
  localparam logic [POS_W-1:0] END_SHORT   = 6'd20;
  localparam logic [POS_W-1:0] END_LONG    = 6'd32;

  typedef logic [HOLD_IDX_W-1:0] hold_idx_t;

  typedef struct packed {
    logic [HOLD_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]           len;
    logic                       last;
    logic [STAT_W-1:0]          movie;
    logic [STAT_W-1:0]          media;
  } entry_t;

endpackage

// ===== rtl/mhtr_front.sv =====
// ----------------------------------------------------------------------------
// mhtr_front
// Tag search, box field parsing, field hold and rewrite; one queue entry per
// passed byte, per finished box, or per held field cut off by the last byte.
// ----------------------------------------------------------------------------
module mhtr_front #(
  parameter int COUNT_BITS = mhtr_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic [1:0]      divide_shift,
  output logic            push,
  output mhtr_pkg::entry_t push_entry
);

  logic [31:0]                  win_r, win_nxt;
  logic [mhtr_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                         long_r, long_nxt;
  logic                         media_r, media_nxt;
  logic [COUNT_BITS-1:0]        mv_r, mv_nxt, mv_upd;
  logic [COUNT_BITS-1:0]        md_r, md_nxt, md_upd;
  logic [7:0]                   held_r [mhtr_pkg::HOLD_BYTES];

  logic [mhtr_pkg::POS_W-1:0]   off, start_v, end_v, diff;
  mhtr_pkg::hold_idx_t          k;
  logic                         in_hold, close, held_we;
  logic [31:0]                  win_sh;
  logic [mhtr_pkg::HOLD_BYTES-1:0][7:0] cur, rw;
  logic [31:0]                  ts, ts_sh;
  logic [63:0]                  dur, dur_sh;

  assign off     = pos_r - 6'd1;
  assign start_v = long_r ? mhtr_pkg::START_LONG : mhtr_pkg::START_SHORT;
  assign end_v   = long_r ? mhtr_pkg::END_LONG : mhtr_pkg::END_SHORT;
  assign diff    = off - start_v;
  assign k       = diff[mhtr_pkg::HOLD_IDX_W-1:0];
  assign in_hold = (pos_r != '0) && (off >= start_v);
  assign close   = in_hold && (off == end_v - 6'd1);
  assign win_sh  = {win_r[23:0], in_byte};

  // held bytes with the current byte merged in
  always_comb begin
    for (int i = 0; i < mhtr_pkg::HOLD_BYTES; i++) begin
      cur[i] = (k == mhtr_pkg::HOLD_IDX_W'(i)) ? in_byte : held_r[i];
    end
  end

  // field rewrite
  always_comb begin
    ts = {cur[0], cur[1], cur[2], cur[3]};
    if (long_r) begin
      dur = {cur[4], cur[5], cur[6], cur[7], cur[8], cur[9], cur[10], cur[11]};
    end else begin
      dur = {32'h0, cur[4], cur[5], cur[6], cur[7]};
    end
    ts_sh  = ts >> divide_shift;
    if (ts_sh == 32'h0) begin
      ts_sh = 32'h1;
    end
    dur_sh = dur >> divide_shift;
    rw     = cur;
    for (int i = 0; i < 4; i++) begin
      rw[i] = ts_sh[8*(3-i) +: 8];
    end
    if (long_r) begin
      for (int i = 0; i < 8; i++) begin
        rw[4+i] = dur_sh[8*(7-i) +: 8];
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        rw[4+i] = dur_sh[8*(3-i) +: 8];
      end
    end
  end

  // saturating box counts
  always_comb begin
    mv_upd = mv_r;
    md_upd = md_r;
    if (accept && close) begin
      if (media_r) begin
        if (md_r != {COUNT_BITS{1'b1}}) begin
          md_upd = md_r + COUNT_BITS'(1);
        end
      end else begin
        if (mv_r != {COUNT_BITS{1'b1}}) begin
          mv_upd = mv_r + COUNT_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    win_nxt    = win_r;
    pos_nxt    = pos_r;
    long_nxt   = long_r;
    media_nxt  = media_r;
    mv_nxt     = mv_upd;
    md_nxt     = md_upd;
    push       = 1'b0;
    held_we    = 1'b0;
    push_entry.bytes    = '0;
    push_entry.bytes[0] = in_byte;
    push_entry.len      = mhtr_pkg::LEN_W'(1);
    push_entry.last     = in_last;
    push_entry.movie    = mhtr_pkg::STAT_W'(mv_upd);
    push_entry.media    = mhtr_pkg::STAT_W'(md_upd);
    if (accept) begin
      if (pos_r == '0) begin
        push    = 1'b1;
        win_nxt = win_sh;
        if (!in_last && (win_sh == mhtr_pkg::TAG_MOVIE || win_sh == mhtr_pkg::TAG_MEDIA)) begin
          media_nxt = (win_sh == mhtr_pkg::TAG_MEDIA);
          pos_nxt   = 6'd1;
        end
      end else begin
        if (off == '0) begin
          long_nxt = (in_byte != 8'h00);
        end
        if (!in_hold) begin
          push    = 1'b1;
          pos_nxt = pos_r + 6'd1;
        end else begin
          held_we = 1'b1;
          if (close || in_last) begin
            push             = 1'b1;
            push_entry.bytes = close ? rw : cur;
            push_entry.len   = mhtr_pkg::LEN_W'(k) + mhtr_pkg::LEN_W'(1);
            win_nxt          = '0;
            pos_nxt          = '0;
            long_nxt         = 1'b0;
            media_nxt        = 1'b0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
      end
      if (in_last) begin
        win_nxt   = '0;
        pos_nxt   = '0;
        long_nxt  = 1'b0;
        media_nxt = 1'b0;
        mv_nxt    = '0;
        md_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      pos_r   <= '0;
      long_r  <= 1'b0;
      media_r <= 1'b0;
      mv_r    <= '0;
      md_r    <= '0;
    end else begin
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      long_r  <= long_nxt;
      media_r <= media_nxt;
      mv_r    <= mv_nxt;
      md_r    <= md_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_r[k] <= in_byte;
    end
  end

endmodule

// ===== rtl/mhtr_queue.sv =====
// ----------------------------------------------------------------------------
// mhtr_queue
// Short fifo of output entries between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module mhtr_queue #(
  parameter int QUEUE_DEPTH = mhtr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mhtr_pkg::entry_t push_entry,
  input  logic             pop,
  output mhtr_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  mhtr_pkg::entry_t   mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/mhtr_back.sv =====
// ----------------------------------------------------------------------------
// mhtr_back
// Byte emitter: unloads one queue entry and sends its bytes one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module mhtr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mhtr_pkg::entry_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  output logic [mhtr_pkg::STAT_W-1:0]   out_movie_headers_patched,
  output logic [mhtr_pkg::STAT_W-1:0]   out_media_headers_patched
);

  logic [mhtr_pkg::HOLD_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [mhtr_pkg::LEN_W-1:0]           left_r, left_nxt;
  logic                                 last_r, last_nxt;
  logic [mhtr_pkg::STAT_W-1:0]          mv_r, mv_nxt, md_r, md_nxt;
  logic                                 taken;

  assign out_valid                 = (left_r != '0);
  assign taken                     = out_valid && !out_stall;
  assign out_byte                  = bytes_r[0];
  assign out_last                  = last_r && (left_r == mhtr_pkg::LEN_W'(1));
  assign out_movie_headers_patched = mv_r;
  assign out_media_headers_patched = md_r;
  assign pop = !empty && ((left_r == '0) || (taken && left_r == mhtr_pkg::LEN_W'(1)));

  always_comb begin
    bytes_nxt = bytes_r;
    left_nxt  = left_r;
    last_nxt  = last_r;
    mv_nxt    = mv_r;
    md_nxt    = md_r;
    if (pop) begin
      bytes_nxt = head.bytes;
      left_nxt  = head.len;
      last_nxt  = head.last;
      mv_nxt    = head.movie;
      md_nxt    = head.media;
    end else if (taken) begin
      for (int i = 0; i < mhtr_pkg::HOLD_BYTES - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
      end
      bytes_nxt[mhtr_pkg::HOLD_BYTES-1] = 8'h00;
      left_nxt = left_r - mhtr_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    last_r  <= last_nxt;
    mv_r    <= mv_nxt;
    md_r    <= md_nxt;
  end

endmodule

// ===== rtl/mp4_header_timescale_rewriter_core.sv =====
// ----------------------------------------------------------------------------
// mp4_header_timescale_rewriter_core
// Rewrites mvhd/mdhd timescale and duration in an mp4 byte stream.
// path: an input transaction is written as a queue entry, then loaded into the emitter's shift register
// throughput: one byte per cycle while out_stall is low; a finished box sends 8 or 12 bytes from one
//   queue entry, one per cycle out of the emitter's shift register
// reset: synchronous active-low rst_n clears parser state, counts and queue
// ----------------------------------------------------------------------------
module mp4_header_timescale_rewriter_core #(
  parameter int COUNT_BITS  = mhtr_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = mhtr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic [mhtr_pkg::STAT_W-1:0] out_movie_headers_patched,
  output logic [mhtr_pkg::STAT_W-1:0] out_media_headers_patched
);

  logic             [1:0] shift_r;
  logic             accept, push, pop, q_empty, q_full;
  mhtr_pkg::entry_t push_entry, head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= mhtr_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  mhtr_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .divide_shift (shift_r),
    .push         (push),
    .push_entry   (push_entry)
  );

  mhtr_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  mhtr_back u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .head                      (head),
    .empty                     (q_empty),
    .pop                       (pop),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_byte                  (out_byte),
    .out_last                  (out_last),
    .out_movie_headers_patched (out_movie_headers_patched),
    .out_media_headers_patched (out_media_headers_patched)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("queue push while full");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_empty)
    else $error("queue pop while empty");
  a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("queue push without input transaction");

endmodule
